/* design/mhpq_pkg.sv */
// ============================================================================
// mhpq_pkg
// shared types, widths and codes of the max-heap priority queue
// ============================================================================
package mhpq_pkg;

    localparam int KEY_W        = 32;
    localparam int CNT_OUT_W    = 7;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 127;

    // item kind carried in the input tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // result status carried in the output tuser
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [KEY_W-1:0] t_key;

    // broadcast to every cell of the sorted row
    typedef struct packed {
        logic ins;
        logic del;
        t_key key;
    } t_cell_ctl;

endpackage

/* design/mhpq_cell.sv */
// ============================================================================
// mhpq_cell
// one slot of the sorted row: keeps, takes the new key or shifts a neighbor
// ============================================================================
module mhpq_cell (
    input  logic                i_clk,
    input  mhpq_pkg::t_cell_ctl i_ctl,
    input  logic                i_occupied,
    input  logic                i_left_ge,
    input  mhpq_pkg::t_key      i_left_key,
    input  mhpq_pkg::t_key      i_right_key,
    output logic                o_ge,
    output mhpq_pkg::t_key      o_key
);

    mhpq_pkg::t_key r_key;
    mhpq_pkg::t_key n_key;

    // own key stays ahead of an incoming equal key
    assign o_ge  = i_occupied && (r_key >= i_ctl.key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        priority if (i_ctl.ins) begin
            priority if (o_ge) begin
                n_key = r_key;
            end else if (i_left_ge) begin
                n_key = i_ctl.key;
            end else begin
                n_key = i_left_key;
            end
        end else if (i_ctl.del) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

/* design/max_heap_priority_queue.sv */
// ============================================================================
// max_heap_priority_queue
// priority queue of signed 32-bit keys giving the maximum after each item
// ============================================================================
//
//  channel   dir  tdata (lsb up)                          tuser
//  s_axis    in   value_in[31:0]                          mode (0 insert, 1 delete)
//  m_axis    out  top_value[31:0], entry_count[38:32], 0  status[1:0]
//
//  each item is applied to the row of cells at the edge where it is accepted,
//  and its result appears in the output register on the next cycle; the one
//  output register sets the rate at one item per cycle as long as results
//  are taken
//  i_rst_n (synchronous, active low) empties the queue and drops any result
//  a stalled result holds; s_axis stays ready while the result is being taken
//
module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // value_in[31:0]
    input  logic [0:0]  i_s_axis_tuser,   // mode[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // top_value[31:0], entry_count[38:32], pad
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // entries held; cells below this count are occupied, kept in descending order
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // output register
    logic                              r_m_valid;
    mhpq_pkg::t_key                    r_m_top;
    logic [mhpq_pkg::CNT_OUT_W-1:0]    r_m_cnt;
    logic [mhpq_pkg::STATUS_W-1:0]     r_m_status;

    logic                              w_accept;
    logic                              w_is_del;
    logic                              w_full;
    logic                              w_empty;
    mhpq_pkg::t_cell_ctl               w_ctl;
    mhpq_pkg::t_key                    w_new_key;
    mhpq_pkg::t_key                    n_top;
    logic [mhpq_pkg::STATUS_W-1:0]     n_status;

    // row taps
    logic                              w_ge  [CAPACITY];
    mhpq_pkg::t_key                    w_key [CAPACITY];

    // ready whenever the output slot is free or being emptied
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_del        = (i_s_axis_tuser[0] == mhpq_pkg::MODE_DELETE);
    assign w_new_key       = i_s_axis_tdata;
    assign w_full          = (r_count == CNT_W'(CAPACITY));
    assign w_empty         = (r_count == '0);

    assign w_ctl.ins = w_accept && !w_is_del && !w_full;
    assign w_ctl.del = w_accept &&  w_is_del && !w_empty;
    assign w_ctl.key = w_new_key;

    // next count, top and status of this item
    always_comb begin
        n_count  = r_count;
        n_status = mhpq_pkg::STATUS_OK;
        n_top    = w_empty ? '0 : w_key[0];
        if (w_is_del) begin
            if (w_empty) begin
                n_status = mhpq_pkg::STATUS_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
                // second cell moves to the front
                if (CAPACITY > 1 && r_count > CNT_W'(1)) begin
                    n_top = w_key[(CAPACITY > 1) ? 1 : 0];
                end else begin
                    n_top = '0;
                end
            end
        end else begin
            if (w_full) begin
                n_status = mhpq_pkg::STATUS_FULL;
            end else begin
                n_count = r_count + 1'b1;
                if (w_empty || (w_new_key > w_key[0])) begin
                    n_top = w_new_key;
                end
            end
        end
    end

    // sorted row of cells, front holds the maximum
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic           w_occ;
        logic           w_lge;
        mhpq_pkg::t_key w_lkey;
        mhpq_pkg::t_key w_rkey;

        assign w_occ = (r_count > CNT_W'(g));

        if (g == 0) begin : g_front
            assign w_lge  = 1'b1;
            assign w_lkey = w_new_key;
        end else begin : g_inner
            assign w_lge  = w_ge[g-1];
            assign w_lkey = w_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign w_rkey = w_key[g];
        end else begin : g_more
            assign w_rkey = w_key[g+1];
        end

        mhpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (w_occ),
            .i_left_ge   (w_lge),
            .i_left_key  (w_lkey),
            .i_right_key (w_rkey),
            .o_ge        (w_ge[g]),
            .o_key       (w_key[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_top    <= n_top;
            r_m_cnt    <= mhpq_pkg::CNT_OUT_W'(n_count);
            r_m_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_m_cnt, r_m_top};
    assign o_m_axis_tuser  = r_m_status;

endmodule

/* design/mhpq_checker.sv */
// ============================================================================
// mhpq_checker
// port-level checks of the max-heap priority queue
// ============================================================================
module mhpq_checker #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    localparam logic [mhpq_pkg::CNT_OUT_W-1:0] CAP_LO = mhpq_pkg::CNT_OUT_W'(CAPACITY);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // every accepted item gives a result on the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted item gave no result");

    // delete on empty reports an empty queue with zero top
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == mhpq_pkg::STATUS_EMPTY) |->
            (o_m_axis_tdata[31:0] == '0) && (o_m_axis_tdata[38:32] == '0))
        else $error("empty status with nonzero top or count");

    // refused insert only at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == mhpq_pkg::STATUS_FULL) |->
            (o_m_axis_tdata[38:32] == CAP_LO))
        else $error("full status below capacity");

    // only defined status codes leave the block
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == mhpq_pkg::STATUS_OK) ||
            (o_m_axis_tuser == mhpq_pkg::STATUS_EMPTY) ||
            (o_m_axis_tuser == mhpq_pkg::STATUS_FULL))
        else $error("undefined status code");

endmodule

bind max_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);
